[rtl/slp_pkg.sv]
// Shared constants, types and the arctangent table for the quaternion slerp block.
// Depends on nothing; every other file in rtl/ uses it by scoped names.
package slp_pkg;

   localparam int CB     = 16;             // component width
   localparam int FRAC   = CB - 1;
   localparam int GW     = CB + 1;         // target component after negation
   localparam int K      = 2 * FRAC - 30;  // rescale of f*g to Q.30
   localparam int KR     = (K >= 0) ? K : 0;
   localparam int KL     = (K < 0) ? -K : 0;
   localparam int DOT_W  = 34;
   localparam int PW     = CB + 33;        // weighted sum width

   localparam int CORDIC_STEPS = 24;
   localparam int SQRT_STEPS   = 31;
   localparam int DIV_STEPS    = 30;
   localparam int STEP_W       = 5;

   localparam int ANG_W = 34;
   localparam int SQ_W  = 62;

   localparam logic [30:0]            ONE_Q30  = 31'h4000_0000;
   localparam logic [DOT_W-1:0]       ONE_DOT  = DOT_W'(64'h4000_0000);
   localparam logic signed [ANG_W-1:0] INV_GAIN = ANG_W'(64'sd652032874);

   localparam longint OUT_HI = (longint'(1) << FRAC) - 1;
   localparam longint OUT_LO = -(longint'(1) << FRAC);

   localparam logic       REG_LINEAR_THRESHOLD = 1'b0;  // index bit of the only register
   localparam logic [15:0] THR_RESET = 16'd66;

   typedef struct packed {
      logic [3:0][CB-1:0] f;
      logic [3:0][GW-1:0] g;
      logic [16:0]        t;
      logic               slerp;
      logic [29:0]        dot;
      logic [30:0]        sw;
   } side_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] th;
      logic signed [ANG_W-1:0] x;
      logic signed [ANG_W-1:0] y;
   } rot_lane_type;

   typedef struct packed {
      logic [31:0] r;
      logic [29:0] q;
      logic        zero;
      logic        full;
   } div_lane_type;

   // atan(2^-i) in Q.30, rounded
   function automatic logic signed [ANG_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
      logic signed [ANG_W-1:0] a;
      case (i)
         5'd0:  a = 34'sd843314857;
         5'd1:  a = 34'sd497837829;
         5'd2:  a = 34'sd263043837;
         5'd3:  a = 34'sd133525159;
         5'd4:  a = 34'sd67021687;
         5'd5:  a = 34'sd33543516;
         5'd6:  a = 34'sd16775851;
         5'd7:  a = 34'sd8388437;
         5'd8:  a = 34'sd4194283;
         5'd9:  a = 34'sd2097149;
         5'd10: a = 34'sd1048576;
         5'd11: a = 34'sd524288;
         5'd12: a = 34'sd262144;
         5'd13: a = 34'sd131072;
         5'd14: a = 34'sd65536;
         5'd15: a = 34'sd32768;
         5'd16: a = 34'sd16384;
         5'd17: a = 34'sd8192;
         5'd18: a = 34'sd4096;
         5'd19: a = 34'sd2048;
         5'd20: a = 34'sd1024;
         5'd21: a = 34'sd512;
         5'd22: a = 34'sd256;
         5'd23: a = 34'sd128;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

[rtl/quaternion_slerp_top.sv]
// Quaternion slerp top level: dot product, square root, CORDIC and division rows.
// Depends on slp_pkg and the cells slp_sqrt_cell, slp_vec_cell, slp_rot_cell, slp_div_cell.
//
// Usage:
//   req_* carries one pair of quaternions and a blend factor per item; rsp_*
//   returns the interpolated quaternion. Both are valid/ready channels.
//   The APB port holds linear_threshold at address 0 (reset 66).
// Throughput: one item per cycle, sustained, as long as rsp_ready is high.
// Depth: the pipeline is made of the square root row (31 cells), the CORDIC
//   vectoring row (24), the CORDIC rotation row (24) and the divider row (30),
//   plus seven stages for the products, dot sum, squaring, angle split,
//   weights, weighted products and output; the first stage loads at the
//   accepting edge.
// Stall: the whole pipeline holds while a result waits in the output
//   register and rsp_ready is low; req_ready is low only then.
// Reset: synchronous; empties the pipeline and loads the threshold default.
//   No clearing pass is needed.
module quaternion_slerp_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [slp_pkg::CB-1:0]  req_from_x,
   input  logic signed [slp_pkg::CB-1:0]  req_from_y,
   input  logic signed [slp_pkg::CB-1:0]  req_from_z,
   input  logic signed [slp_pkg::CB-1:0]  req_from_w,
   input  logic signed [slp_pkg::CB-1:0]  req_target_x,
   input  logic signed [slp_pkg::CB-1:0]  req_target_y,
   input  logic signed [slp_pkg::CB-1:0]  req_target_z,
   input  logic signed [slp_pkg::CB-1:0]  req_target_w,
   input  logic [16:0]                    req_blend,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [slp_pkg::CB-1:0]  rsp_out_x,
   output logic signed [slp_pkg::CB-1:0]  rsp_out_y,
   output logic signed [slp_pkg::CB-1:0]  rsp_out_z,
   output logic signed [slp_pkg::CB-1:0]  rsp_out_w,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [2:0]                     paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   // ---------------- configuration ----------------
   logic [15:0] thr_ff;
   logic        cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && (paddr[2] == slp_pkg::REG_LINEAR_THRESHOLD);
   assign prdata = (paddr[2] == slp_pkg::REG_LINEAR_THRESHOLD) ? {16'd0, thr_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= slp_pkg::THR_RESET;
      end else if (cfg_wr) begin
         thr_ff <= pwdata[15:0];
      end
   end

   // ---------------- flow control ----------------
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;

   // ---------------- stage 1: products ----------------
   logic signed [slp_pkg::CB-1:0]   req_f [4];
   logic signed [slp_pkg::CB-1:0]   req_g [4];
   logic                            p1_vld_ff;
   logic [3:0][slp_pkg::CB-1:0]     p1_f_ff, p1_g_ff;
   logic [16:0]                     p1_t_ff;
   logic signed [2*slp_pkg::CB-1:0] p1_prod_ff [4];
   logic signed [2*slp_pkg::CB-1:0] p1_prod_in [4];
   logic [16:0]                     p1_t_in;

   always_comb begin
      req_f[0] = req_from_x;   req_f[1] = req_from_y;
      req_f[2] = req_from_z;   req_f[3] = req_from_w;
      req_g[0] = req_target_x; req_g[1] = req_target_y;
      req_g[2] = req_target_z; req_g[3] = req_target_w;
      for (int c = 0; c < 4; c++) begin
         p1_prod_in[c] = req_f[c] * req_g[c];
      end
      p1_t_in = (req_blend > 17'd65536) ? 17'd65536 : req_blend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 4; c++) begin
            p1_f_ff[c]    <= req_f[c];
            p1_g_ff[c]    <= req_g[c];
            p1_prod_ff[c] <= p1_prod_in[c];
         end
         p1_t_ff <= p1_t_in;
      end
   end

   // ---------------- stage 2: dot, short arc, path select ----------------
   logic signed [slp_pkg::DOT_W-1:0] scaled [4];
   logic signed [slp_pkg::DOT_W-1:0] dot_sum;
   logic [slp_pkg::DOT_W-1:0]        dot_abs;
   logic [slp_pkg::DOT_W-1:0]        thr_ext;
   logic signed [slp_pkg::GW-1:0]    g_ext;
   logic                             dot_neg;
   slp_pkg::side_type                side2_in, side2_ff;
   logic                             p2_vld_ff;

   always_comb begin
      dot_sum = '0;
      for (int c = 0; c < 4; c++) begin
         scaled[c] = slp_pkg::DOT_W'(p1_prod_ff[c] >>> slp_pkg::KR) <<< slp_pkg::KL;
         dot_sum   = dot_sum + scaled[c];
      end
      dot_neg = dot_sum[slp_pkg::DOT_W-1];
      dot_abs = dot_neg ? slp_pkg::DOT_W'(-dot_sum) : slp_pkg::DOT_W'(dot_sum);
      thr_ext = slp_pkg::DOT_W'({thr_ff, 14'd0});
      side2_in = '0;
      for (int c = 0; c < 4; c++) begin
         g_ext          = slp_pkg::GW'($signed(p1_g_ff[c]));
         side2_in.f[c]  = p1_f_ff[c];
         side2_in.g[c]  = dot_neg ? slp_pkg::GW'(-g_ext) : slp_pkg::GW'(g_ext);
      end
      side2_in.t     = p1_t_ff;
      side2_in.slerp = (dot_abs < slp_pkg::ONE_DOT) &&
                       ((slp_pkg::ONE_DOT - dot_abs) > thr_ext);
      side2_in.dot   = dot_abs[29:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else if (adv) begin
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side2_ff <= side2_in;
      end
   end

   // ---------------- stage 3: 1 - dot^2 ----------------
   logic [59:0]               dot_sq;
   logic [slp_pkg::SQ_W-1:0]  rad_ff;
   slp_pkg::side_type         side3_ff;
   logic                      p3_vld_ff;

   assign dot_sq = side2_ff.dot * side2_ff.dot;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_vld_ff <= 1'b0;
      end else if (adv) begin
         p3_vld_ff <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff   <= (slp_pkg::SQ_W'(1) << 60) - slp_pkg::SQ_W'(dot_sq);
         side3_ff <= side2_ff;
      end
   end

   // ---------------- square root row: sin W ----------------
   logic                     sq_vld  [0:slp_pkg::SQRT_STEPS];
   logic [slp_pkg::SQ_W-1:0] sq_rem  [0:slp_pkg::SQRT_STEPS];
   logic [slp_pkg::SQ_W-1:0] sq_res  [0:slp_pkg::SQRT_STEPS];
   slp_pkg::side_type        sq_side [0:slp_pkg::SQRT_STEPS];

   assign sq_vld[0]  = p3_vld_ff;
   assign sq_rem[0]  = rad_ff;
   assign sq_res[0]  = '0;
   assign sq_side[0] = side3_ff;

   for (genvar i = 0; i < slp_pkg::SQRT_STEPS; i++) begin : g_sqrt
      slp_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .step      (slp_pkg::STEP_W'(i)),
         .prev_vld  (sq_vld[i]),
         .prev_rem  (sq_rem[i]),
         .prev_res  (sq_res[i]),
         .prev_side (sq_side[i]),
         .vld_ff    (sq_vld[i+1]),
         .rem_ff    (sq_rem[i+1]),
         .res_ff    (sq_res[i+1]),
         .side_ff   (sq_side[i+1])
      );
   end

   // ---------------- vectoring row: W = atan2(sin W, dot) ----------------
   logic                             vc_vld  [0:slp_pkg::CORDIC_STEPS];
   logic signed [slp_pkg::ANG_W-1:0] vc_x    [0:slp_pkg::CORDIC_STEPS];
   logic signed [slp_pkg::ANG_W-1:0] vc_y    [0:slp_pkg::CORDIC_STEPS];
   logic signed [slp_pkg::ANG_W-1:0] vc_z    [0:slp_pkg::CORDIC_STEPS];
   slp_pkg::side_type                vc_side [0:slp_pkg::CORDIC_STEPS];
   slp_pkg::side_type                vc_side0;

   always_comb begin
      vc_side0       = sq_side[slp_pkg::SQRT_STEPS];
      vc_side0.sw    = sq_res[slp_pkg::SQRT_STEPS][30:0];
      // zero sin W falls back to the linear weights
      vc_side0.slerp = vc_side0.slerp && (vc_side0.sw != 31'd0);
   end

   assign vc_vld[0]  = sq_vld[slp_pkg::SQRT_STEPS];
   assign vc_x[0]    = slp_pkg::ANG_W'(vc_side0.dot);
   assign vc_y[0]    = slp_pkg::ANG_W'(vc_side0.sw);
   assign vc_z[0]    = '0;
   assign vc_side[0] = vc_side0;

   for (genvar i = 0; i < slp_pkg::CORDIC_STEPS; i++) begin : g_vec
      slp_vec_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .step      (slp_pkg::STEP_W'(i)),
         .prev_vld  (vc_vld[i]),
         .prev_x    (vc_x[i]),
         .prev_y    (vc_y[i]),
         .prev_z    (vc_z[i]),
         .prev_side (vc_side[i]),
         .vld_ff    (vc_vld[i+1]),
         .x_ff      (vc_x[i+1]),
         .y_ff      (vc_y[i+1]),
         .z_ff      (vc_z[i+1]),
         .side_ff   (vc_side[i+1])
      );
   end

   // ---------------- stage 4: split W into tW and (1-t)W ----------------
   logic signed [slp_pkg::ANG_W-1:0] om_z;
   logic [30:0]                      om_in;
   logic [47:0]                      om_t;
   logic [30:0]                      om_ff, tb_ff;
   slp_pkg::side_type                side4_ff;
   logic                             p4_vld_ff;

   always_comb begin
      om_z  = vc_z[slp_pkg::CORDIC_STEPS];
      om_in = (om_z < 0) ? 31'd0 : om_z[30:0];
      om_t  = om_in * vc_side[slp_pkg::CORDIC_STEPS].t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_vld_ff <= 1'b0;
      end else if (adv) begin
         p4_vld_ff <= vc_vld[slp_pkg::CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         om_ff    <= om_in;
         tb_ff    <= om_t[46:16];
         side4_ff <= vc_side[slp_pkg::CORDIC_STEPS];
      end
   end

   // ---------------- rotation row: the two sines ----------------
   logic                  rt_vld  [0:slp_pkg::CORDIC_STEPS];
   slp_pkg::rot_lane_type rt_a    [0:slp_pkg::CORDIC_STEPS];
   slp_pkg::rot_lane_type rt_b    [0:slp_pkg::CORDIC_STEPS];
   slp_pkg::side_type     rt_side [0:slp_pkg::CORDIC_STEPS];

   always_comb begin
      rt_a[0].th = slp_pkg::ANG_W'(om_ff - tb_ff);
      rt_a[0].x  = slp_pkg::INV_GAIN;
      rt_a[0].y  = '0;
      rt_b[0].th = slp_pkg::ANG_W'(tb_ff);
      rt_b[0].x  = slp_pkg::INV_GAIN;
      rt_b[0].y  = '0;
   end

   assign rt_vld[0]  = p4_vld_ff;
   assign rt_side[0] = side4_ff;

   for (genvar i = 0; i < slp_pkg::CORDIC_STEPS; i++) begin : g_rot
      slp_rot_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .step      (slp_pkg::STEP_W'(i)),
         .prev_vld  (rt_vld[i]),
         .prev_a    (rt_a[i]),
         .prev_b    (rt_b[i]),
         .prev_side (rt_side[i]),
         .vld_ff    (rt_vld[i+1]),
         .a_ff      (rt_a[i+1]),
         .b_ff      (rt_b[i+1]),
         .side_ff   (rt_side[i+1])
      );
   end

   // ---------------- divider row: sin * 2^30 / sin W ----------------
   logic                  dv_vld  [0:slp_pkg::DIV_STEPS];
   slp_pkg::div_lane_type dv_a    [0:slp_pkg::DIV_STEPS];
   slp_pkg::div_lane_type dv_b    [0:slp_pkg::DIV_STEPS];
   slp_pkg::side_type     dv_side [0:slp_pkg::DIV_STEPS];

   function automatic slp_pkg::div_lane_type div_start(input logic signed [slp_pkg::ANG_W-1:0] sn,
                                                       input logic [30:0] d);
      slp_pkg::div_lane_type l;
      l.q    = '0;
      l.zero = (sn <= 0);
      // quotient of one or more clamps to one
      l.full = !l.zero && (sn >= $signed(slp_pkg::ANG_W'(d)));
      l.r    = (l.zero || l.full) ? 32'd0 : {1'b0, sn[30:0]};
      return l;
   endfunction

   always_comb begin
      dv_a[0] = div_start(rt_a[slp_pkg::CORDIC_STEPS].y, rt_side[slp_pkg::CORDIC_STEPS].sw);
      dv_b[0] = div_start(rt_b[slp_pkg::CORDIC_STEPS].y, rt_side[slp_pkg::CORDIC_STEPS].sw);
   end

   assign dv_vld[0]  = rt_vld[slp_pkg::CORDIC_STEPS];
   assign dv_side[0] = rt_side[slp_pkg::CORDIC_STEPS];

   for (genvar i = 0; i < slp_pkg::DIV_STEPS; i++) begin : g_div
      slp_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .prev_vld  (dv_vld[i]),
         .prev_a    (dv_a[i]),
         .prev_b    (dv_b[i]),
         .prev_side (dv_side[i]),
         .vld_ff    (dv_vld[i+1]),
         .a_ff      (dv_a[i+1]),
         .b_ff      (dv_b[i+1]),
         .side_ff   (dv_side[i+1])
      );
   end

   // ---------------- stage 6: weights ----------------
   slp_pkg::div_lane_type la, lb;
   slp_pkg::side_type     sd, side6_ff;
   logic [30:0]           wa, wb, w1_lin, w0_in, w1_in;
   logic [30:0]           w0_ff, w1_ff;
   logic                  p6_vld_ff;

   always_comb begin
      la     = dv_a[slp_pkg::DIV_STEPS];
      lb     = dv_b[slp_pkg::DIV_STEPS];
      sd     = dv_side[slp_pkg::DIV_STEPS];
      wa     = la.zero ? 31'd0 : (la.full ? slp_pkg::ONE_Q30 : {1'b0, la.q});
      wb     = lb.zero ? 31'd0 : (lb.full ? slp_pkg::ONE_Q30 : {1'b0, lb.q});
      w1_lin = {sd.t, 14'd0};
      w0_in  = sd.slerp ? wa : slp_pkg::ONE_Q30 - w1_lin;
      w1_in  = sd.slerp ? wb : w1_lin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p6_vld_ff <= 1'b0;
      end else if (adv) begin
         p6_vld_ff <= dv_vld[slp_pkg::DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w0_ff    <= w0_in;
         w1_ff    <= w1_in;
         side6_ff <= sd;
      end
   end

   // ---------------- stage 7: weighted products ----------------
   logic signed [31:0]               w0_s, w1_s;
   logic signed [slp_pkg::PW-1:0]    pa_in [4];
   logic signed [slp_pkg::PW-1:0]    pb_in [4];
   logic signed [slp_pkg::PW-1:0]    pa_ff [4];
   logic signed [slp_pkg::PW-1:0]    pb_ff [4];
   logic signed [slp_pkg::CB-1:0]    fs;
   logic signed [slp_pkg::GW-1:0]    gs;
   logic                             p7_vld_ff;

   always_comb begin
      w0_s = $signed({1'b0, w0_ff});
      w1_s = $signed({1'b0, w1_ff});
      for (int c = 0; c < 4; c++) begin
         fs       = $signed(side6_ff.f[c]);
         gs       = $signed(side6_ff.g[c]);
         pa_in[c] = w0_s * fs;
         pb_in[c] = w1_s * gs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p7_vld_ff <= 1'b0;
      end else if (adv) begin
         p7_vld_ff <= p6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 4; c++) begin
            pa_ff[c] <= pa_in[c];
            pb_ff[c] <= pb_in[c];
         end
      end
   end

   // ---------------- stage 8: round, saturate, output register ----------------
   logic signed [slp_pkg::PW-1:0] acc, shr;
   logic signed [slp_pkg::CB-1:0] out_in [4];
   logic signed [slp_pkg::CB-1:0] out_ff [4];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         acc = pa_ff[c] + pb_ff[c] + slp_pkg::PW'(64'sh2000_0000);
         shr = acc >>> 30;
         if (shr > slp_pkg::PW'(slp_pkg::OUT_HI)) begin
            out_in[c] = slp_pkg::CB'(slp_pkg::OUT_HI);
         end else if (shr < slp_pkg::PW'(slp_pkg::OUT_LO)) begin
            out_in[c] = slp_pkg::CB'(slp_pkg::OUT_LO);
         end else begin
            out_in[c] = slp_pkg::CB'(shr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= p7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 4; c++) begin
            out_ff[c] <= out_in[c];
         end
      end
   end

   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];
   assign rsp_out_w = out_ff[3];

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_linear_sum: assert property (@(posedge clock) disable iff (reset)
      (p6_vld_ff && !side6_ff.slerp) |->
         ((32'(w0_ff) + 32'(w1_ff)) == 32'(slp_pkg::ONE_Q30)))
      else $error("linear weights do not sum to one");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      p6_vld_ff |-> (w0_ff <= slp_pkg::ONE_Q30 && w1_ff <= slp_pkg::ONE_Q30))
      else $error("weight above one");

   a_div_flags: assert property (@(posedge clock) disable iff (reset)
      dv_vld[slp_pkg::DIV_STEPS] |->
         !(la.zero && la.full) && !(lb.zero && lb.full))
      else $error("divider lane both zero and full");

   a_cfg_write: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> (thr_ff == $past(pwdata[15:0])))
      else $error("threshold write lost");
`endif

endmodule

[rtl/slp_sqrt_cell.sv]
// One digit of the pipelined integer square root (two radicand bits per cell).
// Depends on slp_pkg.
module slp_sqrt_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic [slp_pkg::STEP_W-1:0]  step,
   input  logic                        prev_vld,
   input  logic [slp_pkg::SQ_W-1:0]    prev_rem,
   input  logic [slp_pkg::SQ_W-1:0]    prev_res,
   input  slp_pkg::side_type           prev_side,
   output logic                        vld_ff,
   output logic [slp_pkg::SQ_W-1:0]    rem_ff,
   output logic [slp_pkg::SQ_W-1:0]    res_ff,
   output slp_pkg::side_type           side_ff
);

   logic [5:0]               pos;
   logic [slp_pkg::SQ_W-1:0] bit_val;
   logic [slp_pkg::SQ_W-1:0] trial;
   logic [slp_pkg::SQ_W-1:0] rem_in;
   logic [slp_pkg::SQ_W-1:0] res_in;

   always_comb begin
      pos     = 6'd60 - {step, 1'b0};
      bit_val = slp_pkg::SQ_W'(1) << pos;
      trial   = prev_res + bit_val;
      if (prev_rem >= trial) begin
         rem_in = prev_rem - trial;
         res_in = (prev_res >> 1) + bit_val;
      end else begin
         rem_in = prev_rem;
         res_in = prev_res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= prev_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         res_ff  <= res_in;
         side_ff <= prev_side;
      end
   end

endmodule

[rtl/slp_vec_cell.sv]
// One CORDIC vectoring step: rotates (x, y) toward the x axis and sums the angle.
// Depends on slp_pkg for widths and the arctangent table.
module slp_vec_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic [slp_pkg::STEP_W-1:0]        step,
   input  logic                              prev_vld,
   input  logic signed [slp_pkg::ANG_W-1:0]  prev_x,
   input  logic signed [slp_pkg::ANG_W-1:0]  prev_y,
   input  logic signed [slp_pkg::ANG_W-1:0]  prev_z,
   input  slp_pkg::side_type                 prev_side,
   output logic                              vld_ff,
   output logic signed [slp_pkg::ANG_W-1:0]  x_ff,
   output logic signed [slp_pkg::ANG_W-1:0]  y_ff,
   output logic signed [slp_pkg::ANG_W-1:0]  z_ff,
   output slp_pkg::side_type                 side_ff
);

   logic signed [slp_pkg::ANG_W-1:0] xs, ys, at;
   logic signed [slp_pkg::ANG_W-1:0] x_in, y_in, z_in;

   always_comb begin
      xs = prev_x >>> step;
      ys = prev_y >>> step;
      at = slp_pkg::atan_q30(step);
      if (prev_y > 0) begin
         x_in = prev_x + ys;
         y_in = prev_y - xs;
         z_in = prev_z + at;
      end else begin
         x_in = prev_x - ys;
         y_in = prev_y + xs;
         z_in = prev_z - at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= prev_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= prev_side;
      end
   end

endmodule

[rtl/slp_rot_cell.sv]
// One CORDIC rotation step for both weight angles side by side.
// Depends on slp_pkg for the lane type and the arctangent table.
module slp_rot_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic [slp_pkg::STEP_W-1:0]  step,
   input  logic                        prev_vld,
   input  slp_pkg::rot_lane_type       prev_a,
   input  slp_pkg::rot_lane_type       prev_b,
   input  slp_pkg::side_type           prev_side,
   output logic                        vld_ff,
   output slp_pkg::rot_lane_type       a_ff,
   output slp_pkg::rot_lane_type       b_ff,
   output slp_pkg::side_type           side_ff
);

   function automatic slp_pkg::rot_lane_type rot_step(input slp_pkg::rot_lane_type l,
                                                      input logic [slp_pkg::STEP_W-1:0] s);
      slp_pkg::rot_lane_type           n;
      logic signed [slp_pkg::ANG_W-1:0] xs, ys, at;
      xs = l.x >>> s;
      ys = l.y >>> s;
      at = slp_pkg::atan_q30(s);
      if (l.th >= 0) begin
         n.x  = l.x - ys;
         n.y  = l.y + xs;
         n.th = l.th - at;
      end else begin
         n.x  = l.x + ys;
         n.y  = l.y - xs;
         n.th = l.th + at;
      end
      return n;
   endfunction

   slp_pkg::rot_lane_type a_in, b_in;

   always_comb begin
      a_in = rot_step(prev_a, step);
      b_in = rot_step(prev_b, step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= prev_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         side_ff <= prev_side;
      end
   end

endmodule

[rtl/slp_div_cell.sv]
// One restoring-division step for both weights: one quotient bit per lane.
// Depends on slp_pkg; the divisor is sin W carried in the side data.
module slp_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   prev_vld,
   input  slp_pkg::div_lane_type  prev_a,
   input  slp_pkg::div_lane_type  prev_b,
   input  slp_pkg::side_type      prev_side,
   output logic                   vld_ff,
   output slp_pkg::div_lane_type  a_ff,
   output slp_pkg::div_lane_type  b_ff,
   output slp_pkg::side_type      side_ff
);

   function automatic slp_pkg::div_lane_type div_step(input slp_pkg::div_lane_type l,
                                                      input logic [30:0] d);
      slp_pkg::div_lane_type n;
      logic [31:0]           r2;
      n  = l;
      r2 = {l.r[30:0], 1'b0};
      if (r2 >= {1'b0, d}) begin
         n.r = r2 - {1'b0, d};
         n.q = {l.q[28:0], 1'b1};
      end else begin
         n.r = r2;
         n.q = {l.q[28:0], 1'b0};
      end
      return n;
   endfunction

   slp_pkg::div_lane_type a_in, b_in;

   always_comb begin
      a_in = div_step(prev_a, prev_side.sw);
      b_in = div_step(prev_b, prev_side.sw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= prev_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         side_ff <= prev_side;
      end
   end

endmodule
